// ===== rtl/core/cdss_pkg.sv =====
// shared types, codes and segment constants of the countdown display scanner
`timescale 1ns / 1ps

package cdss_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_DISABLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_BLANK   = 2'd0,
    PH_HOURS   = 2'd1,
    PH_MINUTES = 2'd2,
    PH_SECONDS = 2'd3
  } phase_e;

  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } adv_t;

  localparam logic [7:0] SEG_BLANK    = 8'hFF;
  localparam logic [7:0] SEG_LETTER_H = 8'h8B;
  localparam logic [7:0] SEG_DOT      = 8'h7F;

  localparam int unsigned InW  = 40;
  localparam int unsigned OutW = 16;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/core/cdss_split.sv =====
// two-stage split of the seconds left into hours, minutes and seconds
`timescale 1ns / 1ps

module cdss_split
  import cdss_pkg::*;
(
  input  logic        clk_i,
  input  adv_t        adv_i,
  input  logic [15:0] period_i,
  input  logic [15:0] elapsed_i,
  output logic [4:0]  hours_o,
  output logic [5:0]  minutes_o,
  output logic [5:0]  seconds_o
);

  // ceil(2^32 / 3600) and ceil(2^18 / 60), exact over the full input range
  localparam logic [20:0] KHour = 21'd1193047;
  localparam logic [12:0] KMin  = 13'd4370;

  logic [15:0] left;
  logic [36:0] hour_prod;
  logic [15:0] left_q, left_d;
  logic [4:0]  hours2_q, hours2_d;

  logic [15:0] rest_full;
  logic [11:0] rest;
  logic [23:0] min_prod;
  logic [11:0] rest_q, rest_d;
  logic [4:0]  hours3_q, hours3_d;
  logic [5:0]  min_q, min_d;
  logic [11:0] sec_full;

  always_comb begin
    left      = period_i - elapsed_i;
    hour_prod = 37'(left) * 37'(KHour);
    left_d    = left;
    hours2_d  = hour_prod[36:32];

    rest_full = left_q - (16'(hours2_q) * 16'd3600);
    rest      = rest_full[11:0];
    min_prod  = 24'(rest) * 24'(KMin);
    rest_d    = rest;
    hours3_d  = hours2_q;
    min_d     = min_prod[23:18];

    sec_full  = rest_q - (12'(min_q) * 12'd60);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2_en) begin
      left_q   <= left_d;
      hours2_q <= hours2_d;
    end
    if (adv_i.s3_en) begin
      rest_q   <= rest_d;
      hours3_q <= hours3_d;
      min_q    <= min_d;
    end
  end

  assign hours_o   = hours3_q;
  assign minutes_o = min_q;
  assign seconds_o = sec_full[5:0];

endmodule

// ===== rtl/core/cdss_view.sv =====
// segment and common line selection for one scan tick
`timescale 1ns / 1ps

module cdss_view
  import cdss_pkg::*;
(
  input  phase_e      phase_i,
  input  logic [1:0]  pos_i,
  input  logic [4:0]  hours_i,
  input  logic [5:0]  minutes_i,
  input  logic [5:0]  seconds_i,
  output logic [2:0]  com_mask_o,
  output logic [7:0]  segments_o
);

  logic [1:0] pos;
  logic [3:0] hour_digit;
  logic [5:0] value;
  logic [9:0] tens_prod;
  logic [2:0] tens;
  logic [5:0] ones_full;

  always_comb begin
    pos        = (pos_i > 2'd2) ? 2'd0 : pos_i;
    hour_digit = (hours_i > 5'd9) ? 4'd9 : hours_i[3:0];
    value      = (phase_i == PH_MINUTES) ? minutes_i : seconds_i;
    // value * 13 >> 7 is value / 10 for value below 64
    tens_prod  = 10'(value) * 10'd13;
    tens       = tens_prod[9:7];
    ones_full  = value - (6'(tens) * 6'd10);

    com_mask_o = 3'b100 >> pos;
    segments_o = SEG_BLANK;
    case (phase_i)
      PH_HOURS: begin
        if (pos == 2'd0) begin
          segments_o = digit_seg(hour_digit);
        end else if (pos == 2'd1) begin
          segments_o = SEG_LETTER_H;
        end
      end
      PH_MINUTES, PH_SECONDS: begin
        if (pos == 2'd0) begin
          segments_o = (value < 6'd10) ? SEG_BLANK : digit_seg({1'b0, tens});
        end else if (pos == 2'd1) begin
          segments_o = digit_seg(ones_full[3:0]);
        end else begin
          segments_o = SEG_DOT;
        end
      end
      default: segments_o = SEG_BLANK;
    endcase
  end

endmodule

// ===== rtl/core/countdown_seven_segment_scanner.sv =====
// countdown seven-segment scanner top level
//
//  channel  dir  tdata fields (low bit up)                    tuser
//  s_axis   in   period[15:0] elapsed_seconds[31:16]          operation[1:0]
//                phase[33:32], zero pad to 40
//  m_axis   out  com_mask[2:0] segments[10:3], zero pad to 16  -
//
//  an input beat passes three register stages (s1, s2, s3) and then lands in the
//  output register; one beat per cycle sustained while the output is not stalled
//  the hours and minutes splits each use one constant multiplier stage
//  load and disable beats retire without a result; stalls back up through
//  the stages, so empty stages keep taking beats while a result waits
//  reset clears the stage valid flags, the display state and the scan position
`timescale 1ns / 1ps

module countdown_seven_segment_scanner
  import cdss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [InW-1:0]    s_axis_tdata,   // period, elapsed_seconds, phase
  input  logic [1:0]        s_axis_tuser,   // operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OutW-1:0]   m_axis_tdata    // com_mask, segments
);

  logic        s1_vld_q, s1_vld_d;
  op_e         s1_op_q;
  phase_e      s1_phase_q;
  logic [15:0] s1_period_q, s1_elapsed_q;

  logic        s2_vld_q, s2_vld_d;
  op_e         s2_op_q;
  phase_e      s2_phase_q;

  logic        s3_vld_q, s3_vld_d;
  op_e         s3_op_q;
  phase_e      s3_phase_q;

  logic        out_vld_q, out_vld_d;
  logic [OutW-1:0] out_data_q, out_data_d;

  logic [1:0]  pos_q, pos_d;
  logic [4:0]  hours_q, hours_d;
  logic [5:0]  minutes_q, minutes_d;
  logic [5:0]  seconds_q, seconds_d;
  logic        on_q, on_d;

  logic        out_rdy, s3_free, s2_free, s1_en, retire;
  adv_t        adv;

  logic [4:0]  new_hours;
  logic [5:0]  new_minutes, new_seconds;
  logic [2:0]  com_mask;
  logic [7:0]  segments;

  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign s3_free       = !s3_vld_q || out_rdy;
  assign s2_free       = !s2_vld_q || s3_free;
  assign s1_en         = !s1_vld_q || s2_free;
  assign s_axis_tready = s1_en;
  assign adv.s2_en     = s2_free;
  assign adv.s3_en     = s3_free;
  assign retire        = s3_vld_q && out_rdy;

  cdss_split u_split (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .period_i  (s1_period_q),
    .elapsed_i (s1_elapsed_q),
    .hours_o   (new_hours),
    .minutes_o (new_minutes),
    .seconds_o (new_seconds)
  );

  cdss_view u_view (
    .phase_i    (s3_phase_q),
    .pos_i      (pos_q),
    .hours_i    (hours_q),
    .minutes_i  (minutes_q),
    .seconds_i  (seconds_q),
    .com_mask_o (com_mask),
    .segments_o (segments)
  );

  always_comb begin
    s1_vld_d   = s1_en ? s_axis_tvalid : s1_vld_q;
    s2_vld_d   = s2_free ? s1_vld_q : s2_vld_q;
    s3_vld_d   = s3_free ? s2_vld_q : s3_vld_q;

    pos_d      = pos_q;
    hours_d    = hours_q;
    minutes_d  = minutes_q;
    seconds_d  = seconds_q;
    on_d       = on_q;
    out_vld_d  = out_rdy ? 1'b0 : out_vld_q;
    out_data_d = out_data_q;

    if (retire) begin
      case (s3_op_q)
        OP_LOAD: begin
          hours_d   = new_hours;
          minutes_d = new_minutes;
          seconds_d = new_seconds;
          on_d      = 1'b1;
        end
        OP_DISABLE: begin
          on_d = 1'b0;
        end
        OP_TICK: begin
          if (on_q) begin
            out_vld_d  = 1'b1;
            out_data_d = {5'd0, segments, com_mask};
            pos_d      = (pos_q >= 2'd2) ? 2'd0 : pos_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pos_q     <= 2'd0;
      hours_q   <= 5'd0;
      minutes_q <= 6'd0;
      seconds_q <= 6'd0;
      on_q      <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      s3_vld_q  <= s3_vld_d;
      out_vld_q <= out_vld_d;
      pos_q     <= pos_d;
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      on_q      <= on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_op_q      <= op_e'(s_axis_tuser);
      s1_period_q  <= s_axis_tdata[15:0];
      s1_elapsed_q <= s_axis_tdata[31:16];
      s1_phase_q   <= phase_e'(s_axis_tdata[33:32]);
    end
    if (s2_free) begin
      s2_op_q    <= s1_op_q;
      s2_phase_q <= s1_phase_q;
    end
    if (s3_free) begin
      s3_op_q    <= s2_op_q;
      s3_phase_q <= s2_phase_q;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/cdss_checker.sv =====
// port-level checks of the countdown display scanner and their binding
`timescale 1ns / 1ps

module cdss_checker
  import cdss_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // exactly one common line and zero padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(m_axis_tdata[2:0]) && m_axis_tdata[15:11] == 5'd0)
    else $error("bad common mask or padding");

  // last position is blank or dot only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == 3'b001 |->
      m_axis_tdata[10:3] == SEG_BLANK || m_axis_tdata[10:3] == SEG_DOT)
    else $error("unexpected pattern on last position");

  // middle position never shows the dot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] == 3'b010 |-> m_axis_tdata[10:3] != SEG_DOT)
    else $error("dot on middle position");

endmodule

bind countdown_seven_segment_scanner cdss_checker u_cdss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_countdown_seven_segment_scanner.sv =====
// self-checking testbench of the countdown seven-segment scanner
`timescale 1ns / 1ps

module tb_countdown_seven_segment_scanner;
  import cdss_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned RAND_BEATS = 724;
  localparam logic [9:0][7:0] SEG_DIGIT = {
    8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic [2:0] com;
    logic [7:0] seg;
  } seg_beat_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] per;
    logic [15:0] ela;
    logic [1:0]  ph;
    logic        fixed;
    logic        gives;
    seg_beat_t   res;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;   // period, elapsed_seconds, phase
  logic [1:0]      s_axis_tuser = '0;   // operation
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;        // com_mask, segments

  countdown_seven_segment_scanner u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predicted display state
  logic [1:0] tb_scan_pos = '0;
  logic [4:0] tb_hours = '0;
  logic [5:0] tb_minutes = '0;
  logic [5:0] tb_seconds = '0;
  logic       tb_lit = 1'b0;

  seg_beat_t seg_q[$];
  int unsigned err_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_load = 0, n_tick = 0, n_off = 0, n_unused = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 0;
  logic        hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic logic [7:0] pair_view(input logic [5:0] v, input logic [1:0] pos);
    logic [7:0] seg;
    if (pos == 2'd0) begin
      seg = (v < 10) ? SEG_BLANK : SEG_DIGIT[v / 10];
    end else if (pos == 2'd1) begin
      seg = SEG_DIGIT[v % 10];
    end else begin
      seg = SEG_DOT;
    end
    return seg;
  endfunction

  function automatic void predict_scan(input logic [1:0] op, input logic [15:0] per,
                                       input logic [15:0] ela, input logic [1:0] ph,
                                       output bit gives, output seg_beat_t res);
    logic [15:0] left;
    int unsigned h, rest, m;
    logic [1:0]  pos;
    logic [7:0]  seg;
    gives = 0;
    res = '0;
    case (op)
      OP_LOAD: begin
        left = per - ela;
        h = left / 3600;
        rest = left - h * 3600;
        m = rest / 60;
        tb_hours = 5'(h);
        tb_minutes = 6'(m);
        tb_seconds = 6'(rest - m * 60);
        tb_lit = 1'b1;
      end
      OP_DISABLE: begin
        tb_lit = 1'b0;
      end
      OP_TICK: begin
        if (tb_lit) begin
          pos = (tb_scan_pos > 2'd2) ? 2'd0 : tb_scan_pos;
          case (ph)
            PH_HOURS: begin
              if (pos == 2'd0) seg = SEG_DIGIT[(tb_hours > 9) ? 9 : tb_hours];
              else if (pos == 2'd1) seg = SEG_LETTER_H;
              else seg = SEG_BLANK;
            end
            PH_MINUTES: seg = pair_view(tb_minutes, pos);
            PH_SECONDS: seg = pair_view(tb_seconds, pos);
            default: seg = SEG_BLANK;
          endcase
          res.com = 3'b100 >> pos;
          res.seg = seg;
          gives = 1;
          tb_scan_pos = (pos == 2'd2) ? 2'd0 : pos + 2'd1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic check_result(input logic [2:0] com, input logic [7:0] seg);
    seg_beat_t want;
    if (seg_q.size() == 0) begin
      report_mismatch("unexpected beat, com_mask", com, 0);
    end else begin
      want = seg_q.pop_front();
      n_checked++;
      if (com !== want.com) report_mismatch("com_mask", com, want.com);
      if (seg !== want.seg) report_mismatch("segments", seg, want.seg);
    end
  endtask

  // drives one input beat in bursts with random gaps, predicts on acceptance
  task automatic put_beat(input logic [1:0] op, input logic [15:0] per,
                          input logic [15:0] ela, input logic [1:0] ph,
                          output bit gives, output seg_beat_t res);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, ph, ela, per};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_scan(op, per, ela, ph, gives, res);
    case (op)
      OP_LOAD: n_load++;
      OP_TICK: n_tick++;
      OP_DISABLE: n_off++;
      default: n_unused++;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] op, input logic [15:0] per,
                                      input logic [15:0] ela, input logic [1:0] ph,
                                      input logic fixed, input logic gives,
                                      input logic [2:0] com, input logic [7:0] seg);
    dir_row_t r;
    r.op = op;
    r.per = per;
    r.ela = ela;
    r.ph = ph;
    r.fixed = fixed;
    r.gives = gives;
    r.res.com = com;
    r.res.seg = seg;
    return r;
  endfunction

  // receiver: changing ready patterns and one long hold-off
  initial begin
    int unsigned mode, mode_left, hold_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata[2:0], m_axis_tdata[10:3]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    bit          gives;
    seg_beat_t   res;
    logic [1:0]  op;
    logic [15:0] per, ela;
    int unsigned r;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 1, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_DISABLE, 16'd0, 16'd0, PH_BLANK, 1, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_LOAD, 16'd0, 16'd0, PH_BLANK, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 1, 1, 3'b100, 8'hC0));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 1, 1, 3'b010, SEG_LETTER_H));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 1, 1, 3'b001, SEG_BLANK));
    rows.push_back(mk_row(OP_LOAD, 16'hFFFF, 16'd0, PH_BLANK, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 1, 1, 3'b100, 8'h90));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 1, 1, 3'b010, 8'hA4));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_SECONDS, 1, 1, 3'b001, SEG_DOT));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_SECONDS, 1, 1, 3'b100, 8'hF9));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_BLANK, 1, 1, 3'b010, SEG_BLANK));
    rows.push_back(mk_row(OP_LOAD, 16'd0, 16'd1, PH_BLANK, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_HOURS, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_LOAD, 16'd5, 16'd0, PH_BLANK, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_SECONDS, 1, 1, 3'b100, SEG_BLANK));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_SECONDS, 1, 1, 3'b010, 8'h92));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_LOAD, 16'hFFFF, 16'd61936, PH_BLANK, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_MINUTES, 0, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, PH_SECONDS, 1, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_DISABLE, 16'd0, 16'd0, PH_BLANK, 1, 0, 3'b000, 8'h00));
    rows.push_back(mk_row(OP_TICK, 16'd0, 16'd0, PH_SECONDS, 1, 0, 3'b000, 8'h00));

    foreach (rows[i]) begin
      put_beat(rows[i].op, rows[i].per, rows[i].ela, rows[i].ph, gives, res);
      if (rows[i].fixed) begin
        if (rows[i].gives) seg_q.push_back(rows[i].res);
      end else if (gives) begin
        seg_q.push_back(res);
      end
    end
    wait_drained();

    for (int i = 0; i < RAND_BEATS; i++) begin
      // long receiver hold-off while ticks keep coming, so the pipe backs up
      if (i == 300) begin
        hold_req <= 1'b1;
        no_gaps = 1;
      end
      if (i == 380) no_gaps = 0;
      if (i == 520) wait_drained();
      if (i == 300) begin
        op = OP_LOAD;
      end else if (i > 300 && i < 380) begin
        op = OP_TICK;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) op = OP_LOAD;
        else if (r < 88) op = OP_TICK;
        else if (r < 94) op = OP_DISABLE;
        else op = OP_UNUSED;
      end
      per = 16'($urandom);
      case ($urandom_range(0, 3))
        0: ela = 16'($urandom);
        1: ela = per - 16'($urandom_range(0, 599));
        2: ela = per - 16'($urandom_range(0, 35999));
        default: ela = per - 16'($urandom_range(36000, 65535));
      endcase
      put_beat(op, per, ela, 2'($urandom_range(0, 3)), gives, res);
      if (gives) seg_q.push_back(res);
    end
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("covered %0d loads, %0d ticks, %0d disables, %0d unused codes",
             n_load, n_tick, n_off, n_unused);
    $display("checked %0d segment beats under random stalls and one long hold-off",
             n_checked);
    if (err_count == 0 && seg_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cdss_pkg.sv
rtl/core/cdss_split.sv
rtl/core/cdss_view.sv
rtl/core/countdown_seven_segment_scanner.sv
rtl/core/cdss_checker.sv
verif/tb_countdown_seven_segment_scanner.sv
